// ===== rtl/lzwd_pkg.sv =====
// Shared types and constants of the LZW decoder.
package lzwd_pkg;

    localparam int CODE_W    = 16;
    localparam int IDX_W     = 9;
    localparam int CNT_W     = 10;
    localparam int LEN_W     = 9;
    localparam int LIT_CODES = 256;
    localparam int LANES     = 8;
    localparam int LANE_W    = 3;
    localparam int DATA_W    = 64;
    localparam int BCNT_W    = 4;
    localparam int QDEPTH    = 4;
    localparam int QPTR_W    = 2;
    localparam int QCNT_W    = 3;

    typedef enum logic [1:0] {
        CMD_LOOK,
        CMD_KWK,
        CMD_ERR
    } t_cmd_kind;

    // One classified code, passed from the front end to the back end
    typedef struct packed {
        t_cmd_kind          kind;
        logic [IDX_W-1:0]   code;
        logic [IDX_W-1:0]   prev;
        logic               append;
        logic [IDX_W-1:0]   idx;
    } t_cmd;

    // One dictionary entry
    typedef struct packed {
        logic [IDX_W-1:0]   prefix;
        logic [7:0]         tail;
        logic [7:0]         head;
        logic [LEN_W-1:0]   len;
    } t_entry;

endpackage

// ===== rtl/lzwd_if.sv =====
// Request channel interfaces of the LZW decoder: codes in, decoded bytes out.
interface lzwd_in_if import lzwd_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [CODE_W-1:0] code;
    logic              stream_start;

    modport source (output valid, output code, output stream_start, input ready);
    modport sink   (input valid, input code, input stream_start, output ready);
endinterface

interface lzwd_out_if import lzwd_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [DATA_W-1:0] data_bytes;
    logic [BCNT_W-1:0] byte_count;
    logic              last_of_run;
    logic              code_error;

    modport source (output valid, output data_bytes, output byte_count,
                    output last_of_run, output code_error, input ready);
    modport sink   (input valid, input data_bytes, input byte_count,
                    input last_of_run, input code_error, output ready);
endinterface

// ===== rtl/lzwd_fe.sv =====
// Front end: accepts codes, tracks stream state and classifies each code.
module lzwd_fe import lzwd_pkg::*; #(
    parameter int DICT_ENTRIES = 512
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    lzwd_in_if.sink   i_in,
    input  logic      i_full,
    output logic      o_push,
    output t_cmd      o_cmd
);

    logic [CNT_W-1:0] r_count, n_count;
    logic [IDX_W-1:0] r_prev, n_prev;
    logic             r_halt, n_halt;
    logic             r_in_stream, n_in_stream;

    logic             accept;
    logic             cmd_valid;
    logic [CNT_W-1:0] cnt_eff;
    logic             halt_eff;
    logic             ins_eff;
    logic             not_full;
    logic             in_dict;
    logic             is_kwk;
    logic             is_lit;

    assign i_in.ready = !i_full;
    assign accept     = i_in.valid && !i_full;
    assign o_push     = accept && cmd_valid;

    always_comb begin
        // a stream start resets the entry count, the halt and the stream state before the code is handled
        cnt_eff  = i_in.stream_start ? CNT_W'(LIT_CODES) : r_count;
        halt_eff = i_in.stream_start ? 1'b0 : r_halt;
        ins_eff  = i_in.stream_start ? 1'b0 : r_in_stream;
        not_full = cnt_eff < CNT_W'(DICT_ENTRIES);
        in_dict  = i_in.code < CODE_W'(cnt_eff);
        is_kwk   = (i_in.code == CODE_W'(cnt_eff)) && not_full;
        is_lit   = i_in.code < CODE_W'(LIT_CODES);

        n_count     = cnt_eff;
        n_prev      = r_prev;
        n_halt      = halt_eff;
        n_in_stream = ins_eff;
        cmd_valid   = 1'b0;
        o_cmd.kind   = CMD_LOOK;
        o_cmd.code   = i_in.code[IDX_W-1:0];
        o_cmd.prev   = r_prev;
        o_cmd.append = 1'b0;
        o_cmd.idx    = cnt_eff[IDX_W-1:0];

        if (!halt_eff) begin
            cmd_valid = 1'b1;
            priority if (!ins_eff) begin
                if (is_lit) begin
                    o_cmd.prev  = i_in.code[IDX_W-1:0];
                    n_prev      = i_in.code[IDX_W-1:0];
                    n_in_stream = 1'b1;
                end else begin
                    o_cmd.kind  = CMD_ERR;
                    n_halt      = 1'b1;
                    n_in_stream = 1'b0;
                end
            end else if (in_dict || is_kwk) begin
                o_cmd.kind   = in_dict ? CMD_LOOK : CMD_KWK;
                o_cmd.append = not_full;
                if (not_full) begin
                    n_count = cnt_eff + 1'b1;
                end
                n_prev = i_in.code[IDX_W-1:0];
            end else begin
                o_cmd.kind  = CMD_ERR;
                n_halt      = 1'b1;
                n_in_stream = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= CNT_W'(LIT_CODES);
            r_prev      <= '0;
            r_halt      <= 1'b0;
            r_in_stream <= 1'b0;
        end else if (accept) begin
            r_count     <= n_count;
            r_prev      <= n_prev;
            r_halt      <= n_halt;
            r_in_stream <= n_in_stream;
        end
    end

endmodule

// ===== rtl/lzwd_cq.sv =====
// Command queue between the front end and the back end.
module lzwd_cq import lzwd_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    output logic o_full,
    input  logic i_pop,
    output logic o_empty,
    output t_cmd o_head
);

    t_cmd              r_mem [QDEPTH];
    logic [QPTR_W-1:0] r_wp;
    logic [QPTR_W-1:0] r_rp;
    logic [QCNT_W-1:0] r_cnt;
    logic              do_push;
    logic              do_pop;

    assign o_full  = r_cnt == QCNT_W'(QDEPTH);
    assign o_empty = r_cnt == '0;
    assign o_head  = r_mem[r_rp];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (do_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            unique case ({do_push, do_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

// ===== rtl/lzwd_be.sv =====
// Back end: dictionary memory, prefix chain walk, string stack and result packing.
module lzwd_be import lzwd_pkg::*; #(
    parameter int DICT_ENTRIES = 512
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_empty,
    input  t_cmd       i_head,
    output logic       o_pop,
    lzwd_out_if.source o_out
);

    localparam int MAX_LEN    = DICT_ENTRIES - LIT_CODES + 2;
    localparam int STACK_ROWS = (MAX_LEN + LANES - 1) / LANES;
    localparam int ROW_W      = (STACK_ROWS > 1) ? $clog2(STACK_ROWS) : 1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_RDC,
        S_ROOT,
        S_WALK,
        S_LIT,
        S_EXTRA,
        S_EMIT_RD,
        S_EMIT_WR
    } t_state;

    t_state            r_state;
    t_cmd              r_cmd;
    t_entry            r_pent;
    logic [7:0]        r_phead;
    logic [LEN_W-1:0]  r_plen;
    logic [7:0]        r_first;
    logic [LEN_W-1:0]  r_pos;
    logic [7:0]        r_lit;
    logic [LEN_W-1:0]  r_rem;
    logic [ROW_W-1:0]  r_row;
    logic              r_out_valid;
    logic [DATA_W-1:0] r_out_data;
    logic [BCNT_W-1:0] r_out_cnt;
    logic              r_out_last;
    logic              r_out_err;

    t_entry            r_dict [DICT_ENTRIES];
    t_entry            r_dict_q;
    logic              dict_re;
    logic [IDX_W-1:0]  dict_ra;
    logic              dict_we;
    logic [IDX_W-1:0]  dict_wa;
    t_entry            dict_wd;

    logic              st_we;
    logic [LEN_W-1:0]  st_pos;
    logic [7:0]        st_data;
    logic [ROW_W-1:0]  st_row;
    logic              row_re;
    wire  [DATA_W-1:0] w_row_q;

    t_entry            root_ent;
    logic [IDX_W-1:0]  root_code;
    logic              root_lit;
    logic [LEN_W-1:0]  root_len;
    t_entry            cur_ent;
    logic              pre_lit;
    logic              p_lit;
    logic              out_free;
    logic              out_take;
    logic [BCNT_W-1:0] emit_cnt;
    logic [DATA_W-1:0] emit_data;
    logic              emit_last;

    assign out_free = !r_out_valid || o_out.ready;
    assign out_take = r_out_valid && o_out.ready;

    assign o_out.valid       = r_out_valid;
    assign o_out.data_bytes  = r_out_data;
    assign o_out.byte_count  = r_out_cnt;
    assign o_out.last_of_run = r_out_last;
    assign o_out.code_error  = r_out_err;

    // Root of the string: the code itself, or the previous code for KwKwK
    assign root_ent  = (r_cmd.kind == CMD_KWK) ? r_pent : r_dict_q;
    assign root_code = (r_cmd.kind == CMD_KWK) ? r_cmd.prev : r_cmd.code;
    assign root_lit  = root_code < IDX_W'(LIT_CODES);
    assign root_len  = root_lit ? LEN_W'(1) : root_ent.len;
    assign cur_ent   = (r_state == S_WALK) ? r_dict_q : root_ent;
    assign pre_lit   = cur_ent.prefix < IDX_W'(LIT_CODES);
    assign p_lit     = r_cmd.prev < IDX_W'(LIT_CODES);
    assign st_row    = st_pos[LANE_W +: ROW_W];

    assign emit_cnt  = (r_rem > LEN_W'(LANES)) ? BCNT_W'(LANES) : r_rem[BCNT_W-1:0];
    assign emit_last = r_rem <= LEN_W'(LANES);

    always_comb begin
        for (int i = 0; i < LANES; i++) begin
            emit_data[8*i +: 8] = (BCNT_W'(i) < emit_cnt) ? w_row_q[8*i +: 8] : 8'h00;
        end
    end

    always_comb begin
        o_pop   = 1'b0;
        dict_re = 1'b0;
        dict_ra = cur_ent.prefix;
        dict_we = 1'b0;
        dict_wa = r_cmd.idx;
        dict_wd = '{prefix: r_cmd.prev, tail: r_first, head: r_phead, len: r_plen + 1'b1};
        st_we   = 1'b0;
        st_pos  = r_pos - 1'b1;
        st_data = cur_ent.tail;
        row_re  = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_pop   = !i_empty;
                dict_re = !i_empty;
                dict_ra = i_head.prev;
            end
            S_RDC: begin
                dict_re = 1'b1;
                dict_ra = r_cmd.code;
            end
            S_ROOT: begin
                if (!root_lit) begin
                    st_we   = 1'b1;
                    st_pos  = root_len - 1'b1;
                    dict_re = !pre_lit;
                end
            end
            S_WALK: begin
                st_we   = 1'b1;
                dict_re = !pre_lit;
            end
            S_LIT: begin
                st_we   = 1'b1;
                st_pos  = '0;
                st_data = r_lit;
                dict_we = r_cmd.append;
            end
            S_EXTRA: begin
                // KwKwK: the string ends with its own first byte
                st_we   = 1'b1;
                st_pos  = r_plen;
                st_data = r_phead;
            end
            S_EMIT_RD: begin
                row_re = 1'b1;
            end
            S_EMIT_WR: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (dict_we) begin
            r_dict[dict_wa] <= dict_wd;
        end
        if (dict_re) begin
            r_dict_q <= r_dict[dict_ra];
        end
    end

    for (genvar l = 0; l < LANES; l++) begin : g_lane
        logic [7:0] r_stack [STACK_ROWS];
        logic [7:0] r_q;

        always_ff @(posedge i_clk) begin
            if (st_we && (st_pos[LANE_W-1:0] == LANE_W'(l))) begin
                r_stack[st_row] <= st_data;
            end
            if (row_re) begin
                r_q <= r_stack[r_row];
            end
        end

        assign w_row_q[8*l +: 8] = r_q;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            if (out_take) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (!i_empty) begin
                        r_cmd   <= i_head;
                        r_state <= (i_head.kind == CMD_ERR) ? S_EMIT_WR : S_RDC;
                    end
                end
                S_RDC: begin
                    r_pent  <= r_dict_q;
                    r_phead <= p_lit ? r_cmd.prev[7:0] : r_dict_q.head;
                    r_plen  <= p_lit ? LEN_W'(1) : r_dict_q.len;
                    r_state <= S_ROOT;
                end
                S_ROOT: begin
                    r_first <= root_lit ? root_code[7:0] : root_ent.head;
                    r_rem   <= (r_cmd.kind == CMD_KWK) ? r_plen + 1'b1 : root_len;
                    r_pos   <= root_len - 1'b1;
                    priority if (root_lit) begin
                        r_lit   <= root_code[7:0];
                        r_state <= S_LIT;
                    end else if (pre_lit) begin
                        r_lit   <= cur_ent.prefix[7:0];
                        r_state <= S_LIT;
                    end else begin
                        r_state <= S_WALK;
                    end
                end
                S_WALK: begin
                    // advance one chain entry per cycle, stop at the literal root
                    r_pos <= r_pos - 1'b1;
                    if (pre_lit) begin
                        r_lit   <= cur_ent.prefix[7:0];
                        r_state <= S_LIT;
                    end
                end
                S_LIT: begin
                    r_row   <= '0;
                    r_state <= (r_cmd.kind == CMD_KWK) ? S_EXTRA : S_EMIT_RD;
                end
                S_EXTRA: begin
                    r_state <= S_EMIT_RD;
                end
                S_EMIT_RD: begin
                    r_state <= S_EMIT_WR;
                end
                S_EMIT_WR: begin
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        if (r_cmd.kind == CMD_ERR) begin
                            r_out_data <= '0;
                            r_out_cnt  <= '0;
                            r_out_last <= 1'b1;
                            r_out_err  <= 1'b1;
                            r_state    <= S_IDLE;
                        end else begin
                            r_out_data <= emit_data;
                            r_out_cnt  <= emit_cnt;
                            r_out_last <= emit_last;
                            r_out_err  <= 1'b0;
                            r_rem      <= r_rem - LEN_W'(emit_cnt);
                            r_row      <= r_row + 1'b1;
                            r_state    <= emit_last ? S_IDLE : S_EMIT_RD;
                        end
                    end
                end
            endcase
        end
    end

endmodule

// ===== rtl/lzw_decoder_top.sv =====
// LZW decoder top level. Takes one 16-bit code per request and returns the decoded
// string as results of up to eight bytes, first byte in the lowest lane, with the
// final result of a code flagged. A front end keeps the stream state (entry count,
// previous code, halt) and classifies each code in the cycle it is accepted; a
// four-deep command queue lets it run ahead of the back end. The back end owns the
// dictionary memory and walks a code's prefix chain one entry per cycle, filling a
// byte stack that is then read out eight bytes at a time. A KwKwK code walks the
// previous string and appends its first byte. A stalled result holds the back end
// until it is taken. The chain walk goes through the dictionary memory read port.
// The dictionary needs no clearing: a stream start only resets the entry count.
module lzw_decoder_top import lzwd_pkg::*; #(
    parameter int DICT_ENTRIES = 512
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    lzwd_in_if.sink     i_in,
    lzwd_out_if.source  o_out
);

    logic push;
    logic pop;
    logic full;
    logic empty;
    t_cmd push_cmd;
    t_cmd head_cmd;

    lzwd_fe #(
        .DICT_ENTRIES (DICT_ENTRIES)
    ) u_fe (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_full  (full),
        .o_push  (push),
        .o_cmd   (push_cmd)
    );

    lzwd_cq u_cq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .o_full  (full),
        .i_pop   (pop),
        .o_empty (empty),
        .o_head  (head_cmd)
    );

    lzwd_be #(
        .DICT_ENTRIES (DICT_ENTRIES)
    ) u_be (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_empty (empty),
        .i_head  (head_cmd),
        .o_pop   (pop),
        .o_out   (o_out)
    );

endmodule

// ===== rtl/lzwd_chk.sv =====
// Port checker for the LZW decoder, bound to the top level.
module lzwd_chk import lzwd_pkg::*; (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_out_valid,
    input logic              i_out_ready,
    input logic [DATA_W-1:0] i_out_data_bytes,
    input logic [BCNT_W-1:0] i_out_byte_count,
    input logic              i_out_last_of_run,
    input logic              i_out_code_error
);

    // An error result carries no bytes and closes its run
    a_err_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_code_error |->
            i_out_byte_count == '0 && i_out_last_of_run && i_out_data_bytes == '0)
        else $error("error result with data or without last flag");

    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_code_error |->
            i_out_byte_count != '0 && i_out_byte_count <= BCNT_W'(LANES))
        else $error("data result byte count out of range");

    // Only the final result of a code may be short
    a_short_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_code_error && i_out_byte_count != BCNT_W'(LANES) |->
            i_out_last_of_run)
        else $error("partial result before the end of a run");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            i_out_valid && $stable(i_out_data_bytes) && $stable(i_out_byte_count) &&
            $stable(i_out_last_of_run) && $stable(i_out_code_error))
        else $error("stalled result changed or dropped");

endmodule

bind lzw_decoder_top lzwd_chk u_chk (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .i_out_valid       (o_out.valid),
    .i_out_ready       (o_out.ready),
    .i_out_data_bytes  (o_out.data_bytes),
    .i_out_byte_count  (o_out.byte_count),
    .i_out_last_of_run (o_out.last_of_run),
    .i_out_code_error  (o_out.code_error)
);

// ===== tb/tb_lzw_decoder_top.sv =====
// Self-checking testbench of the LZW decoder: directed table, random code streams, own predictor.
`timescale 1ns / 100ps

module tb_lzw_decoder_top import lzwd_pkg::*; ();

    localparam int DICT_SIZE   = 512;
    localparam int IDX_MASK    = 511;
    localparam int QUIET_LIMIT = 5000;
    localparam int TAIL_CYCLES = 400;

    typedef enum logic [1:0] {
        ROW_PREDICT,
        ROW_NONE,
        ROW_WORD,
        ROW_ERROR
    } t_row_kind;

    typedef struct packed {
        t_row_kind          kind;
        logic [CODE_W-1:0]  code;
        logic               ss;
        logic [DATA_W-1:0]  data;
        logic [BCNT_W-1:0]  count;
    } t_row;

    typedef struct {
        logic [DATA_W-1:0]  data;
        logic [BCNT_W-1:0]  count;
        logic               last;
        logic               err;
    } t_decoded_word;

    // Typed rows expect a single literal byte, an error word or nothing at all
    localparam t_row DIRECTED [25] = '{
        '{ROW_WORD,    16'h0041, 1'b0, 64'h41, 4'd1},
        '{ROW_WORD,    16'h0042, 1'b0, 64'h42, 4'd1},
        '{ROW_PREDICT, 16'h0100, 1'b0, 64'h0,  4'd0},
        '{ROW_PREDICT, 16'h0102, 1'b0, 64'h0,  4'd0},
        '{ROW_WORD,    16'h0000, 1'b0, 64'h0,  4'd1},
        '{ROW_WORD,    16'h00FF, 1'b0, 64'hFF, 4'd1},
        '{ROW_PREDICT, 16'h0103, 1'b0, 64'h0,  4'd0},
        '{ROW_ERROR,   16'hFFFF, 1'b0, 64'h0,  4'd0},
        '{ROW_NONE,    16'h0010, 1'b0, 64'h0,  4'd0},
        '{ROW_NONE,    16'hFFFF, 1'b0, 64'h0,  4'd0},
        '{ROW_ERROR,   16'hFFFF, 1'b1, 64'h0,  4'd0},
        '{ROW_ERROR,   16'h0100, 1'b1, 64'h0,  4'd0},
        '{ROW_WORD,    16'h0000, 1'b1, 64'h0,  4'd1},
        '{ROW_ERROR,   16'h0101, 1'b0, 64'h0,  4'd0},
        '{ROW_WORD,    16'h0080, 1'b1, 64'h80, 4'd1},
        '{ROW_PREDICT, 16'h0100, 1'b0, 64'h0,  4'd0},
        '{ROW_PREDICT, 16'h0101, 1'b0, 64'h0,  4'd0},
        '{ROW_PREDICT, 16'h0102, 1'b0, 64'h0,  4'd0},
        '{ROW_PREDICT, 16'h0100, 1'b0, 64'h0,  4'd0},
        '{ROW_WORD,    16'h00AA, 1'b1, 64'hAA, 4'd1},
        '{ROW_WORD,    16'h0055, 1'b1, 64'h55, 4'd1},
        '{ROW_ERROR,   16'h7FFF, 1'b0, 64'h0,  4'd0},
        '{ROW_NONE,    16'h0001, 1'b0, 64'h0,  4'd0},
        '{ROW_WORD,    16'h0001, 1'b1, 64'h01, 4'd1},
        '{ROW_PREDICT, 16'h00FE, 1'b0, 64'h0,  4'd0}
    };

    logic i_clk;
    logic i_rst_n;

    lzwd_in_if  code_if ();
    lzwd_out_if word_if ();

    lzw_decoder_top u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (code_if),
        .o_out   (word_if)
    );

    // Predictor state
    logic [IDX_W-1:0] dict_prefix [DICT_SIZE];
    logic [7:0]       dict_tail   [DICT_SIZE];
    logic [7:0]       dict_head   [DICT_SIZE];
    logic [LEN_W-1:0] dict_len    [DICT_SIZE];
    logic [7:0]       spell_buf   [DICT_SIZE];
    int unsigned      next_entry;
    logic [IDX_W-1:0] last_code;
    bit               halted;
    bit               streaming;

    t_decoded_word    step_words [$];
    t_decoded_word    expected_words [$];
    t_decoded_word    exp_w;

    int unsigned      fail_count = 0;
    int unsigned      stim_items;
    int unsigned      send_idle_pct;
    int unsigned      recv_stall_pct;
    int unsigned      quiet_cycles;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic int unsigned chain_len(int unsigned c);
        return (c < LIT_CODES) ? 1 : int'(dict_len[c & IDX_MASK]);
    endfunction

    function automatic logic [7:0] chain_head(int unsigned c);
        return (c < LIT_CODES) ? 8'(c) : dict_head[c & IDX_MASK];
    endfunction

    // Walk the prefix chain backwards into spell_buf; return the string length
    function automatic int unsigned spell(int unsigned c);
        int unsigned n;
        int unsigned pos;
        int unsigned cur;
        n = chain_len(c);
        if (n < 1) n = 1;
        if (n > 511) n = 511;
        pos = n;
        cur = c;
        while (cur >= LIT_CODES && pos > 1) begin
            pos--;
            spell_buf[pos] = dict_tail[cur & IDX_MASK];
            cur = dict_prefix[cur & IDX_MASK];
        end
        spell_buf[0] = chain_head(cur);
        return n;
    endfunction

    function automatic void pack_words(int unsigned n);
        int unsigned   words;
        int unsigned   cnt;
        logic [63:0]   d;
        t_decoded_word w;
        words = (n + 7) / 8;
        for (int unsigned k = 0; k < words; k++) begin
            cnt = n - k * 8;
            if (cnt > 8) cnt = 8;
            d = '0;
            for (int unsigned i = 0; i < cnt; i++)
                d[8*i +: 8] = spell_buf[(k * 8 + i) & IDX_MASK];
            w.data  = d;
            w.count = 4'(cnt);
            w.last  = (k + 1 == words);
            w.err   = 1'b0;
            step_words.push_back(w);
        end
    endfunction

    function automatic void halt_on_error();
        t_decoded_word w;
        halted    = 1'b1;
        streaming = 1'b0;
        w.data  = '0;
        w.count = '0;
        w.last  = 1'b1;
        w.err   = 1'b1;
        step_words.push_back(w);
    endfunction

    // Decode one accepted code into step_words and advance the dictionary
    function automatic void decode_step(logic [CODE_W-1:0] code, bit ss);
        int unsigned n;
        int unsigned c;
        int unsigned pv;
        logic [7:0]  fb;
        step_words.delete();
        c = code;
        if (ss) begin
            next_entry = LIT_CODES;
            halted     = 1'b0;
            streaming  = 1'b0;
        end
        if (halted) return;
        if (!streaming) begin
            if (c >= LIT_CODES) begin
                halt_on_error();
                return;
            end
            spell_buf[0] = code[7:0];
            last_code    = code[IDX_W-1:0];
            streaming    = 1'b1;
            pack_words(1);
            return;
        end
        pv = last_code;
        if (c < next_entry) begin
            n  = spell(c);
            fb = chain_head(c);
        end else if (c == next_entry && next_entry < DICT_SIZE) begin
            // KwKwK: previous string plus its own first byte
            n  = spell(pv);
            fb = chain_head(pv);
            spell_buf[n & IDX_MASK] = fb;
            n++;
        end else begin
            halt_on_error();
            return;
        end
        if (next_entry < DICT_SIZE) begin
            dict_prefix[next_entry] = 9'(pv);
            dict_tail[next_entry]   = fb;
            dict_head[next_entry]   = chain_head(pv);
            dict_len[next_entry]    = 9'(chain_len(pv) + 1);
            next_entry++;
        end
        last_code = code[IDX_W-1:0];
        pack_words(n);
    endfunction

    task automatic send_code(logic [CODE_W-1:0] code, bit ss, t_row_kind kind,
                             logic [DATA_W-1:0] data, logic [BCNT_W-1:0] count);
        t_decoded_word w;
        bit            ignored;
        while ($urandom_range(0, 99) < send_idle_pct) begin
            code_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        code_if.valid        <= 1'b1;
        code_if.code         <= code;
        code_if.stream_start <= ss;
        @(posedge i_clk);
        while (!code_if.ready) @(posedge i_clk);
        ignored = halted && !ss;
        if (!ignored) stim_items++;
        decode_step(code, ss);
        case (kind)
            ROW_PREDICT: begin
                foreach (step_words[i]) expected_words.push_back(step_words[i]);
            end
            ROW_WORD: begin
                w.data  = data;
                w.count = count;
                w.last  = 1'b1;
                w.err   = 1'b0;
                expected_words.push_back(w);
            end
            ROW_ERROR: begin
                w.data  = '0;
                w.count = '0;
                w.last  = 1'b1;
                w.err   = 1'b1;
                expected_words.push_back(w);
            end
            default: ;
        endcase
    endtask

    // Codes sent while halted: dropped by the block
    task automatic send_ignored();
        repeat ($urandom_range(0, 2))
            send_code(16'($urandom), 1'b0, ROW_PREDICT, '0, '0);
    endtask

    task automatic run_stream(int unsigned n, int unsigned kwk_pct, int unsigned err_pct);
        int unsigned       r;
        logic [CODE_W-1:0] c;
        if ($urandom_range(0, 19) == 0) begin
            send_code(16'($urandom_range(LIT_CODES, 65535)), 1'b1, ROW_PREDICT, '0, '0);
            send_ignored();
            return;
        end
        send_code(16'($urandom_range(0, LIT_CODES - 1)), 1'b1, ROW_PREDICT, '0, '0);
        repeat (n) begin
            r = $urandom_range(0, 99);
            if (r < err_pct) begin
                c = 16'($urandom_range(
                        (next_entry < DICT_SIZE) ? next_entry + 1 : DICT_SIZE, 65535));
                send_code(c, 1'b0, ROW_PREDICT, '0, '0);
                send_ignored();
                return;
            end else if (r < err_pct + kwk_pct && next_entry < DICT_SIZE) begin
                c = 16'(next_entry);
            end else if (r < err_pct + kwk_pct + 25) begin
                c = 16'($urandom_range(0, LIT_CODES - 1));
            end else begin
                c = 16'($urandom_range(0, next_entry - 1));
            end
            send_code(c, 1'b0, ROW_PREDICT, '0, '0);
        end
    endtask

    // Result side: random stall, compare against the oldest expectation
    always @(posedge i_clk) begin
        word_if.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
        if (i_rst_n && word_if.valid && word_if.ready) begin
            if (expected_words.size() == 0) begin
                $display("%0t: unexpected result: data %h count %0d last %b err %b", $time,
                         word_if.data_bytes, word_if.byte_count, word_if.last_of_run,
                         word_if.code_error);
                fail_count++;
            end else begin
                exp_w = expected_words.pop_front();
                if (word_if.data_bytes !== exp_w.data) begin
                    $display("%0t: data_bytes expected %h actual %h", $time,
                             exp_w.data, word_if.data_bytes);
                    fail_count++;
                end
                if (word_if.byte_count !== exp_w.count) begin
                    $display("%0t: byte_count expected %0d actual %0d", $time,
                             exp_w.count, word_if.byte_count);
                    fail_count++;
                end
                if (word_if.last_of_run !== exp_w.last) begin
                    $display("%0t: last_of_run expected %b actual %b", $time,
                             exp_w.last, word_if.last_of_run);
                    fail_count++;
                end
                if (word_if.code_error !== exp_w.err) begin
                    $display("%0t: code_error expected %b actual %b", $time,
                             exp_w.err, word_if.code_error);
                    fail_count++;
                end
            end
        end
    end

    // Watchdog: end the run if no request moves for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (code_if.valid && code_if.ready) || (word_if.valid && word_if.ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == QUIET_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        i_rst_n              <= 1'b0;
        code_if.valid        <= 1'b0;
        code_if.code         <= '0;
        code_if.stream_start <= 1'b0;
        stim_items     = 0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        for (int i = 0; i < DICT_SIZE; i++) begin
            dict_prefix[i] = '0;
            dict_tail[i]   = '0;
            dict_head[i]   = '0;
            dict_len[i]    = '0;
            spell_buf[i]   = '0;
        end
        next_entry = LIT_CODES;
        last_code  = '0;
        halted     = 1'b0;
        streaming  = 1'b0;

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (DIRECTED[i])
            send_code(DIRECTED[i].code, DIRECTED[i].ss, DIRECTED[i].kind,
                      DIRECTED[i].data, DIRECTED[i].count);

        for (int idle_phase = 0; idle_phase < 4; idle_phase++) begin
            send_idle_pct  = (idle_phase == 1) ? 68 : (idle_phase == 3) ? 28 : 0;
            recv_stall_pct = (idle_phase == 2) ? 68 : (idle_phase == 3) ? 28 : 0;
            if (idle_phase == 2) begin
                // Fill the dictionary, then read its top entry and overrun it
                run_stream(268, 85, 0);
                send_code(16'(DICT_SIZE - 1), 1'b0, ROW_PREDICT, '0, '0);
                send_code(16'(DICT_SIZE), 1'b0, ROW_PREDICT, '0, '0);
            end
            stim_items = 0;
            while (stim_items < 38)
                run_stream($urandom_range(1, 20), 30, 3);
        end
        code_if.valid <= 1'b0;

        while (expected_words.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
